[rtl/lmcs_pkg.sv]
package lmcs_pkg;

  // Default number of drivers in the chain.
  localparam int CHAIN_LEN_DEF = 4;

  // Command codes of the input channel.
  localparam logic [2:0] CMD_BCAST   = 3'd0;
  localparam logic [2:0] CMD_COL_ONE = 3'd1;
  localparam logic [2:0] CMD_COL_ALL = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_INIT    = 3'd4;

  // Driver register addresses.
  localparam logic [3:0] REG_NOOP         = 4'h0;
  localparam logic [3:0] REG_DECODE       = 4'h9;
  localparam logic [3:0] REG_INTENSITY    = 4'ha;
  localparam logic [3:0] REG_SCAN_LIMIT   = 4'hb;
  localparam logic [3:0] REG_SHUTDOWN     = 4'hc;
  localparam logic [3:0] REG_DISPLAY_TEST = 4'hf;

  // Frame counts less one for the multi-frame commands.
  localparam logic [2:0] CLEAR_FRAMES_M1 = 3'd7;
  localparam logic [2:0] INIT_FRAMES_M1  = 3'd4;

  // Packet geometry: 16 bits on the wire, the low 12 carry address and data.
  localparam int PKT_W = 16;
  localparam int PAY_W = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_OUT
  } state_t;

  function automatic logic [3:0] init_addr(input logic [2:0] idx);
    logic [3:0] a;
    unique case (idx)
      3'd0:    a = REG_SCAN_LIMIT;
      3'd1:    a = REG_DECODE;
      3'd2:    a = REG_SHUTDOWN;
      3'd3:    a = REG_DISPLAY_TEST;
      3'd4:    a = REG_INTENSITY;
      default: a = REG_NOOP;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] init_data(input logic [2:0] idx);
    logic [7:0] d;
    unique case (idx)
      3'd0:    d = 8'h07;
      3'd1:    d = 8'h00;
      3'd2:    d = 8'h01;
      3'd3:    d = 8'h00;
      3'd4:    d = 8'h0f;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

[rtl/lmcs_in_if.sv]
interface lmcs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] reg_address;
  logic [4:0] column;
  logic [7:0] value;

  modport source (output valid, command, reg_address, column, value, input ready);
  modport sink (input valid, command, reg_address, column, value, output ready);
endinterface

[rtl/lmcs_out_if.sv]
interface lmcs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] packet_address;
  logic [7:0] packet_data;
  logic       frame_end;
  logic       last;

  modport source (output valid, packet_address, packet_data, frame_end, last, input ready);
  modport sink (input valid, packet_address, packet_data, frame_end, last, output ready);
endinterface

[rtl/led_matrix_chain_serializer.sv]
// Turns one command into frames of 16-bit driver packets, one packet per chained
// device, device 0 first. Each packet is built in a transmit shift register and
// moved MSB first, one bit per clock, into the output register, from which it
// is offered to the sink. Broadcast and column commands send one frame, init
// five and clear eight. A new command is taken only after the last packet of
// the previous one has left; command codes above init are taken and dropped
// without any result.
module led_matrix_chain_serializer import lmcs_pkg::*; #(
  parameter int CHAIN_LEN = CHAIN_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lmcs_in_if.sink           in_chan,
  lmcs_out_if.source        out_chan
);

  localparam int DEV_W = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;
  localparam int CMP_W = 3;
  localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(CHAIN_LEN - 1);

  state_t state_r, state_nxt;

  logic [2:0]       cmd_r, cmd_nxt;
  logic [3:0]       addr_r, addr_nxt;
  logic [4:0]       col_r, col_nxt;
  logic [7:0]       val_r, val_nxt;
  logic [2:0]       frame_r, frame_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [PKT_W-1:0] tx_sr_r, tx_sr_nxt;
  logic [PAY_W-1:0] rx_sr_r, rx_sr_nxt;

  logic       in_hs, out_hs;
  logic       hit;
  logic [3:0] pkt_addr;
  logic [7:0] pkt_data;
  logic [2:0] frames_m1;
  logic       dev_is_last, frame_is_last;

  assign in_hs  = in_chan.valid && in_chan.ready;
  assign out_hs = out_chan.valid && out_chan.ready;

  assign dev_is_last   = (dev_r == DEV_LAST);
  assign frame_is_last = (frame_r == frames_m1);

  // Packet contents for the current frame and device.
  always_comb begin
    hit = (cmd_r != CMD_COL_ONE) || (CMP_W'(dev_r) == CMP_W'(col_r[4:3]));
    frames_m1 = 3'd0;
    pkt_addr  = REG_NOOP;
    pkt_data  = 8'h00;
    unique case (cmd_r)
      CMD_BCAST: begin
        pkt_addr = addr_r;
        pkt_data = val_r;
      end
      CMD_COL_ONE, CMD_COL_ALL: begin
        pkt_addr = {1'b0, col_r[2:0]} + 4'd1;
        pkt_data = val_r;
      end
      CMD_CLEAR: begin
        frames_m1 = CLEAR_FRAMES_M1;
        pkt_addr  = {1'b0, frame_r} + 4'd1;
        pkt_data  = 8'h00;
      end
      CMD_INIT: begin
        frames_m1 = INIT_FRAMES_M1;
        pkt_addr  = init_addr(frame_r);
        pkt_data  = init_data(frame_r);
      end
      default: begin
        pkt_addr = REG_NOOP;
        pkt_data = 8'h00;
      end
    endcase
    if (!hit) begin
      pkt_addr = REG_NOOP;
      pkt_data = 8'h00;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_hs && (in_chan.command <= CMD_INIT)) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (bit_cnt_r == 4'd15) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_hs) state_nxt = (dev_is_last && frame_is_last) ? ST_IDLE : ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    cmd_nxt     = cmd_r;
    addr_nxt    = addr_r;
    col_nxt     = col_r;
    val_nxt     = val_r;
    frame_nxt   = frame_r;
    dev_nxt     = dev_r;
    bit_cnt_nxt = bit_cnt_r;
    tx_sr_nxt   = tx_sr_r;
    rx_sr_nxt   = rx_sr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          cmd_nxt   = in_chan.command;
          addr_nxt  = in_chan.reg_address;
          col_nxt   = in_chan.column;
          val_nxt   = in_chan.value;
          frame_nxt = 3'd0;
          dev_nxt   = '0;
        end
      end
      ST_LOAD: begin
        tx_sr_nxt   = {4'h0, pkt_addr, pkt_data};
        bit_cnt_nxt = 4'd0;
      end
      ST_SHIFT: begin
        rx_sr_nxt   = {rx_sr_r[PAY_W-2:0], tx_sr_r[PKT_W-1]};
        tx_sr_nxt   = {tx_sr_r[PKT_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 4'd1;
      end
      ST_OUT: begin
        if (out_hs) begin
          if (dev_is_last) begin
            dev_nxt   = '0;
            frame_nxt = frame_r + 3'd1;
          end else begin
            dev_nxt = dev_r + DEV_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    in_chan.ready           = (state_r == ST_IDLE);
    out_chan.valid          = (state_r == ST_OUT);
    out_chan.packet_address = rx_sr_r[PAY_W-1:8];
    out_chan.packet_data    = rx_sr_r[7:0];
    out_chan.frame_end      = dev_is_last;
    out_chan.last           = dev_is_last && frame_is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      frame_r   <= 3'd0;
      dev_r     <= '0;
      bit_cnt_r <= 4'd0;
      cmd_r     <= CMD_BCAST;
    end else begin
      state_r   <= state_nxt;
      frame_r   <= frame_nxt;
      dev_r     <= dev_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    col_r   <= col_nxt;
    val_r   <= val_nxt;
    tx_sr_r <= tx_sr_nxt;
    rx_sr_r <= rx_sr_nxt;
  end

endmodule

[bench/led_matrix_chain_serializer_tb.sv]
module led_matrix_chain_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmcs_pkg::*;

  localparam int CHAIN = CHAIN_LEN_DEF;
  localparam int CLEAR_FRAMES = 8;
  localparam int INIT_FRAMES = 5;
  localparam logic [2:0] CMD_MAX_CODE = 3'd7;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } packet_t;

  logic clk;
  logic rst_n;

  lmcs_in_if  in_chan();
  lmcs_out_if out_chan();

  led_matrix_chain_serializer #(.CHAIN_LEN(CHAIN)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  packet_t expected_packets[$];
  int mismatch_count = 0;
  int packets_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [3:0] init_reg_seq[INIT_FRAMES] = '{REG_SCAN_LIMIT, REG_DECODE, REG_SHUTDOWN,
                                            REG_DISPLAY_TEST, REG_INTENSITY};
  logic [7:0] init_val_seq[INIT_FRAMES] = '{8'h07, 8'h00, 8'h01, 8'h00, 8'h0f};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A negative target addresses every device in the chain.
  function automatic int push_frame(logic [3:0] addr, logic [7:0] data, int target);
    packet_t pkt;
    bit hit;
    for (int i = 0; i < CHAIN; i++) begin
      hit = (target < 0) || (i == target);
      pkt.addr = hit ? addr : REG_NOOP;
      pkt.data = hit ? data : 8'h00;
      pkt.frame_end = (i == CHAIN - 1);
      pkt.last = 1'b0;
      expected_packets.push_back(pkt);
    end
    return CHAIN;
  endfunction

  function automatic void predict_packets(logic [2:0] cmd, logic [3:0] reg_addr,
                                          logic [4:0] col, logic [7:0] val);
    int produced;
    logic [3:0] digit;
    produced = 0;
    digit = {1'b0, col[2:0]} + 4'd1;
    unique case (cmd)
      CMD_BCAST:   produced += push_frame(reg_addr, val, -1);
      CMD_COL_ONE: produced += push_frame(digit, val, int'(col[4:3]));
      CMD_COL_ALL: produced += push_frame(digit, val, -1);
      CMD_CLEAR: begin
        for (int f = 0; f < CLEAR_FRAMES; f++)
          produced += push_frame(4'(f + 1), 8'h00, -1);
      end
      CMD_INIT: begin
        for (int f = 0; f < INIT_FRAMES; f++)
          produced += push_frame(init_reg_seq[f], init_val_seq[f], -1);
      end
      default: ;
    endcase
    if (produced > 0)
      expected_packets[expected_packets.size() - 1].last = 1'b1;
  endfunction

  // Called and returns at a falling edge; valid stays high into the next call
  // unless that call starts with idle cycles.
  task automatic issue_command(logic [2:0] cmd, logic [3:0] reg_addr,
                               logic [4:0] col, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.command     <= cmd;
    in_chan.reg_address <= reg_addr;
    in_chan.column      <= col;
    in_chan.value       <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_packets(cmd, reg_addr, col, val);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    packet_t want;
    packet_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.packet_address, out_chan.packet_data,
              out_chan.frame_end, out_chan.last};
      if (expected_packets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("packet %0d unexpected: addr %h data %h frame_end %b last %b",
                   packets_seen, got.addr, got.data, got.frame_end, got.last);
      end else begin
        want = expected_packets.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("packet %0d: expected %h %h %b %b, got %h %h %b %b",
                     packets_seen, want.addr, want.data, want.frame_end, want.last,
                     got.addr, got.data, got.frame_end, got.last);
        end
      end
      packets_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_matrix_chain_serializer: mismatch");
      $finish;
    end
  end

  task automatic test_broadcast();
    issue_command(CMD_BCAST, 4'hf, 5'($urandom_range(31)), 8'hff);
    issue_command(CMD_BCAST, 4'h0, 5'($urandom_range(31)), 8'h00);
    issue_command(CMD_BCAST, REG_INTENSITY, 5'($urandom_range(31)), 8'h5a);
  endtask

  // Every column edge of every device, including the last one in the chain.
  task automatic test_column_one();
    logic [4:0] cols[8] = '{5'd0, 5'd7, 5'd8, 5'd15, 5'd16, 5'd23, 5'd24, 5'd31};
    for (int i = 0; i < 8; i++)
      issue_command(CMD_COL_ONE, 4'($urandom_range(15)), cols[i],
                    (i % 2) ? 8'hff : 8'h00);
  endtask

  // The device bits of the column must be ignored here.
  task automatic test_column_all();
    issue_command(CMD_COL_ALL, 4'($urandom_range(15)), 5'd0, 8'h81);
    issue_command(CMD_COL_ALL, 4'($urandom_range(15)), 5'd7, 8'hff);
    issue_command(CMD_COL_ALL, 4'($urandom_range(15)), 5'd13, 8'h3c);
    issue_command(CMD_COL_ALL, 4'($urandom_range(15)), 5'd31, 8'h00);
  endtask

  task automatic test_clear_and_init();
    issue_command(CMD_CLEAR, 4'hf, 5'd31, 8'hff);
    issue_command(CMD_INIT, 4'hf, 5'd31, 8'hff);
    issue_command(CMD_CLEAR, 4'h0, 5'd0, 8'h00);
  endtask

  // Unused codes are consumed without output; the broadcast after them shows
  // the block is still taking commands.
  task automatic test_unknown_commands();
    for (int c = CMD_INIT + 1; c <= CMD_MAX_CODE; c++)
      issue_command(3'(c), 4'($urandom_range(15)), 5'($urandom_range(31)),
                    8'($urandom_range(255)));
    issue_command(CMD_BCAST, 4'h5, 5'd0, 8'ha5);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int num_items);
    int sent;
    int pick;
    logic [2:0] cmd;
    logic [7:0] val;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < num_items) begin
      pick = $urandom_range(99);
      if (pick < 10)      cmd = 3'($urandom_range(CMD_MAX_CODE, CMD_INIT + 1));
      else if (pick < 35) cmd = CMD_BCAST;
      else if (pick < 60) cmd = CMD_COL_ONE;
      else if (pick < 80) cmd = CMD_COL_ALL;
      else if (pick < 90) cmd = CMD_INIT;
      else                cmd = CMD_CLEAR;
      if ($urandom_range(7) == 0)
        val = $urandom_range(1) ? 8'hff : 8'h00;
      else
        val = 8'($urandom_range(255));
      issue_command(cmd, 4'($urandom_range(15)), 5'($urandom_range(31)), val);
      sent++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = CMD_BCAST;
    in_chan.reg_address = '0;
    in_chan.column = '0;
    in_chan.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_broadcast();
    test_column_one();
    test_column_all();
    test_clear_and_init();
    test_unknown_commands();
    test_random_traffic(0, 0, 62);
    test_random_traffic(77, 0, 62);
    test_random_traffic(0, 77, 62);
    test_random_traffic(11, 11, 62);

    in_chan.valid <= 1'b0;
    while (expected_packets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_packets.size() == 0) begin
      $display("led_matrix_chain_serializer: match");
    end else begin
      $display("led_matrix_chain_serializer: mismatch");
    end
    $finish;
  end

endmodule
